>>> rtl/core/double_ended_priority_queue_top_macros.svh
// Assertion macros for the priority queue checker.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define DEPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that only applies while an output beat is presented.
`define DEPQ_ASSERT_OUT(lbl, clk, rst_n, vld, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld |-> (prop))) \
        else $error(msg);

`endif

>>> rtl/core/depq_pkg.sv
package depq_pkg;

    localparam int DEPTH     = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 7;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEL_MAX = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    function automatic logic [OUT_CNT_W-1:0] count_out(input t_count c);
        logic [CNT_W+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, c};
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/double_ended_priority_queue_top.sv
// Double-ended priority queue of signed 32-bit values.
// Input channel: i_valid / o_stall with i_op and i_value. A beat is taken on
// a rising edge with i_valid high and o_stall low. Ops: insert, remove max,
// remove min, clear.
// Output channel: o_valid / i_stall. Each input beat gives exactly one output
// beat with the max, min, empty flag and count after the op, plus a dropped
// flag for an insert refused because the queue was full.
// The result is registered and shown in the cycle after the input beat.
// Throughput: one beat per cycle while o_stall is low. Two rows of cells
// (ascending and descending copies of the contents) shift by one place per
// op, so max and min always sit in the first cell of each row.
// When the receiver stalls with a result pending, o_stall rises and the
// result holds until taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; no clearing pass is needed, entries past the count are never read.
module double_ended_priority_queue_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_op,
    input  logic signed [31:0]       i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [31:0]       o_max_value,
    output logic signed [31:0]       o_min_value,
    output logic                     o_is_empty,
    output logic [6:0]               o_entry_count,
    output logic                     o_dropped
);

    depq_pkg::t_count    r_cnt;
    depq_pkg::t_count    n_cnt;
    logic                r_out_valid;
    depq_pkg::t_value    r_max;
    depq_pkg::t_value    r_min;
    logic                r_empty;
    logic [depq_pkg::OUT_CNT_W-1:0] r_cnt_out;
    logic                r_dropped;

    logic                w_accept;
    logic                w_full;
    logic                w_nonempty;
    logic                w_ins;
    logic                w_del_max;
    logic                w_del_min;
    logic                w_drop;
    depq_pkg::t_cell_ctl w_asc_ctl;
    depq_pkg::t_cell_ctl w_desc_ctl;
    depq_pkg::t_value    w_asc_first;
    depq_pkg::t_value    w_desc_first;

    assign o_stall    = r_out_valid && i_stall;
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_cnt == depq_pkg::CNT_W'(depq_pkg::DEPTH));
    assign w_nonempty = (r_cnt != '0);

    assign w_ins     = w_accept && (i_op == depq_pkg::OP_INSERT) && !w_full;
    assign w_drop    = w_accept && (i_op == depq_pkg::OP_INSERT) && w_full;
    assign w_del_max = w_accept && (i_op == depq_pkg::OP_DEL_MAX) && w_nonempty;
    assign w_del_min = w_accept && (i_op == depq_pkg::OP_DEL_MIN) && w_nonempty;

    assign w_asc_ctl  = '{ins: w_ins, pop: w_del_min};
    assign w_desc_ctl = '{ins: w_ins, pop: w_del_max};

    depq_chain u_asc (
        .i_clk     (i_clk),
        .i_ctl     (w_asc_ctl),
        .i_desc    (1'b0),
        .i_count   (r_cnt),
        .i_value   (i_value),
        .o_n_first (w_asc_first)
    );

    depq_chain u_desc (
        .i_clk     (i_clk),
        .i_ctl     (w_desc_ctl),
        .i_desc    (1'b1),
        .i_count   (r_cnt),
        .i_value   (i_value),
        .o_n_first (w_desc_first)
    );

    always_comb begin
        priority if (w_ins) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_del_max || w_del_min) begin
            n_cnt = r_cnt - 1'b1;
        end else if (w_accept && (i_op == depq_pkg::OP_CLEAR)) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_empty   <= (n_cnt == '0);
            r_max     <= (n_cnt == '0) ? '0 : w_desc_first;
            r_min     <= (n_cnt == '0) ? '0 : w_asc_first;
            r_cnt_out <= depq_pkg::count_out(n_cnt);
            r_dropped <= w_drop;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_max_value   = r_max;
    assign o_min_value   = r_min;
    assign o_is_empty    = r_empty;
    assign o_entry_count = r_cnt_out;
    assign o_dropped     = r_dropped;

endmodule

>>> rtl/core/depq_cell.sv
module depq_cell (
    input  logic                i_clk,
    input  depq_pkg::t_cell_ctl i_ctl,
    input  logic                i_desc,
    input  logic                i_occ,
    input  depq_pkg::t_value    i_value,
    input  logic                i_left_keep,
    input  depq_pkg::t_value    i_left_value,
    input  depq_pkg::t_value    i_right_value,
    output logic                o_keep,
    output depq_pkg::t_value    o_value,
    output depq_pkg::t_value    o_n_value
);

    depq_pkg::t_value r_value;
    depq_pkg::t_value n_value;

    // keep: this entry stays ahead of the new value in the chain order
    assign o_keep = i_occ && (i_desc ? (r_value >= i_value) : (r_value <= i_value));

    always_comb begin
        priority if (i_ctl.ins) begin
            priority if (o_keep) begin
                n_value = r_value;
            end else if (i_left_keep) begin
                n_value = i_value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value   = r_value;
    assign o_n_value = n_value;

endmodule

>>> rtl/core/depq_chain.sv
module depq_chain (
    input  logic                i_clk,
    input  depq_pkg::t_cell_ctl i_ctl,
    input  logic                i_desc,
    input  depq_pkg::t_count    i_count,
    input  depq_pkg::t_value    i_value,
    output depq_pkg::t_value    o_n_first
);

    logic             w_keep   [depq_pkg::DEPTH];
    logic             w_occ    [depq_pkg::DEPTH];
    depq_pkg::t_value w_val    [depq_pkg::DEPTH];
    depq_pkg::t_value w_n_val  [depq_pkg::DEPTH];
    logic             w_lkeep  [depq_pkg::DEPTH];
    depq_pkg::t_value w_lval   [depq_pkg::DEPTH];
    depq_pkg::t_value w_rval   [depq_pkg::DEPTH];

    for (genvar g = 0; g < depq_pkg::DEPTH; g++) begin : g_cell
        assign w_occ[g] = (depq_pkg::CNT_W'(g) < i_count);

        if (g == 0) begin : g_head
            assign w_lkeep[g] = 1'b1;
            assign w_lval[g]  = i_value;
        end else begin : g_body
            assign w_lkeep[g] = w_keep[g-1];
            assign w_lval[g]  = w_val[g-1];
        end

        if (g == depq_pkg::DEPTH - 1) begin : g_tail
            assign w_rval[g] = '0;
        end else begin : g_mid
            assign w_rval[g] = w_val[g+1];
        end

        depq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_desc        (i_desc),
            .i_occ         (w_occ[g]),
            .i_value       (i_value),
            .i_left_keep   (w_lkeep[g]),
            .i_left_value  (w_lval[g]),
            .i_right_value (w_rval[g]),
            .o_keep        (w_keep[g]),
            .o_value       (w_val[g]),
            .o_n_value     (w_n_val[g])
        );
    end

    assign o_n_first = w_n_val[0];

endmodule

>>> rtl/core/depq_checker.sv
`include "double_ended_priority_queue_top_macros.svh"

module depq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_op,
    input logic signed [31:0] i_value,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_max_value,
    input logic signed [31:0] o_min_value,
    input logic               o_is_empty,
    input logic [6:0]         o_entry_count,
    input logic               o_dropped
);

    `DEPQ_ASSERT_OUT(a_empty_count, i_clk, i_rst_n, o_valid, o_is_empty == (o_entry_count == 7'd0), "empty flag disagrees with count")
    `DEPQ_ASSERT_OUT(a_empty_zero, i_clk, i_rst_n, o_valid, !o_is_empty || (o_max_value == 32'sd0 && o_min_value == 32'sd0), "empty queue reports nonzero max or min")
    `DEPQ_ASSERT_OUT(a_order, i_clk, i_rst_n, o_valid, o_is_empty || (o_min_value <= o_max_value), "min above max")
    `DEPQ_ASSERT_OUT(a_drop_full, i_clk, i_rst_n, o_valid, !o_dropped || !o_is_empty, "drop reported with empty queue")
    `DEPQ_ASSERT(a_accept_gives_beat, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_valid, "accepted beat gave no result")

endmodule

bind double_ended_priority_queue_top depq_checker u_depq_checker (.*);
